/* src/dsc_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dsc_pkg
// Shared widths, constants and codes of the Doppler-shift correlator.
// -----------------------------------------------------------------------------
package dsc_pkg;

	localparam int SPECTRUM_LENGTH = 4096;
	localparam int BIN_W           = $clog2(SPECTRUM_LENGTH);
	localparam int MAX_COLUMNS     = 1024;
	localparam int COL_W           = 10;
	localparam int STEP_W          = 26;
	localparam int FRAC_W          = 16;
	localparam int COUNT_W         = 11;
	localparam int SAMPLE_W        = 16;
	localparam int WORD_W          = 2 * SAMPLE_W;
	localparam int PROD_W          = 2 * SAMPLE_W + 1;
	localparam int MAP_W           = 22;
	localparam int OFFS_PROD_W     = STEP_W + COL_W;

	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(512);

	// register index, taken from paddr[2]
	localparam logic REG_STEP  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam logic KIND_LOAD      = 1'b0;
	localparam logic KIND_CORRELATE = 1'b1;

endpackage

/* src/dsc_ram.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dsc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module dsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/dsc_addr_gen.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dsc_addr_gen
// Doppler offset round(step*column) and wrapped spectrum read address.
// -----------------------------------------------------------------------------
module dsc_addr_gen (
	input  logic                        clk,
	input  logic                        en,
	input  logic [dsc_pkg::STEP_W-1:0]  step,
	input  logic [dsc_pkg::COL_W-1:0]   column,
	input  logic [dsc_pkg::BIN_W-1:0]   bin_index,
	output logic [dsc_pkg::BIN_W-1:0]   rd_addr
);

	localparam int RND_W = dsc_pkg::FRAC_W + dsc_pkg::BIN_W;
	localparam logic [RND_W-1:0] HALF = RND_W'(1) << (dsc_pkg::FRAC_W - 1);

	logic [dsc_pkg::OFFS_PROD_W-1:0] offs_prod_s1;
	logic [RND_W-1:0]                rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			offs_prod_s1 <= dsc_pkg::OFFS_PROD_W'(step) * dsc_pkg::OFFS_PROD_W'(column);
		end
	end

	// only the bits that survive the modulo are needed
	assign rnd     = offs_prod_s1[RND_W-1:0] + HALF;
	assign rd_addr = bin_index + rnd[dsc_pkg::FRAC_W +: dsc_pkg::BIN_W];

endmodule

/* src/dsc_cmul.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dsc_cmul
// Exact complex product ref * conj(bin): registered partial products, then sums.
// -----------------------------------------------------------------------------
module dsc_cmul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [dsc_pkg::SAMPLE_W-1:0] ref_re,
	input  logic signed [dsc_pkg::SAMPLE_W-1:0] ref_im,
	input  logic [dsc_pkg::WORD_W-1:0]          bin_word,
	output logic signed [dsc_pkg::PROD_W-1:0]   prod_re,
	output logic signed [dsc_pkg::PROD_W-1:0]   prod_im
);

	localparam int PP_W = 2 * dsc_pkg::SAMPLE_W;

	logic signed [dsc_pkg::SAMPLE_W-1:0] x_re;
	logic signed [dsc_pkg::SAMPLE_W-1:0] x_im;
	logic signed [PP_W-1:0] rr_s1, ii_s1, ir_s1, ri_s1;

	// store word: real part high, imaginary low
	assign x_re = bin_word[dsc_pkg::WORD_W-1:dsc_pkg::SAMPLE_W];
	assign x_im = bin_word[dsc_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1 <= ref_re * x_re;
			ii_s1 <= ref_im * x_im;
			ir_s1 <= ref_im * x_re;
			ri_s1 <= ref_re * x_im;
		end
	end

	assign prod_re = {rr_s1[PP_W-1], rr_s1} + {ii_s1[PP_W-1], ii_s1};
	assign prod_im = {ir_s1[PP_W-1], ir_s1} - {ri_s1[PP_W-1], ri_s1};

endmodule

/* src/doppler_shift_correlator.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// doppler_shift_correlator
// Frequency-domain cross-ambiguity cell: reference times conjugate of a
// Doppler-shifted surveillance bin held in a 4096-entry spectrum RAM.
// -----------------------------------------------------------------------------
// A load request writes one surveillance bin into the spectrum RAM. A
// correlate request steps the sequencer through offset multiply, RAM read
// at (bin_index + round(step*column)) mod 4096, partial products and final
// sums into the output register; s_tready is low meanwhile.
// The output register lets the next request in while a result waits on
// m_tready. Bins must be loaded before they are correlated against; there is
// no clearing of the spectrum RAM. A column at or past column_count returns
// zeros with bad_column set. Registers: 0x0 doppler_step (Q10.16), 0x4
// column_count; write them only while the block is idle.
// -----------------------------------------------------------------------------
module doppler_shift_correlator (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // bin_index[11:0], sample_re[27:12], sample_im[43:28], column[53:44]
	input  logic        s_tuser,  // kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // prod_re[32:0], prod_im[65:33], map_address[87:66]
	output logic        m_tuser   // bad_column
);

	localparam int BIN_W    = dsc_pkg::BIN_W;
	localparam int COL_W    = dsc_pkg::COL_W;
	localparam int SAMPLE_W = dsc_pkg::SAMPLE_W;
	localparam int PROD_W   = dsc_pkg::PROD_W;
	localparam int MAP_W    = dsc_pkg::MAP_W;
	localparam int COUNT_W  = dsc_pkg::COUNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OFFS = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_MULT = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;

	logic [dsc_pkg::STEP_W-1:0] step_q;
	logic [COUNT_W-1:0]         count_q;
	logic                       cfg_wr;

	logic [2:0] state_q;

	logic [BIN_W-1:0]           in_bin;
	logic signed [SAMPLE_W-1:0] in_re;
	logic signed [SAMPLE_W-1:0] in_im;
	logic [COL_W-1:0]           in_col;
	logic                       in_acc;

	logic [BIN_W-1:0]           bin_q;
	logic signed [SAMPLE_W-1:0] re_q;
	logic signed [SAMPLE_W-1:0] im_q;
	logic [COL_W-1:0]           col_q;
	logic                       bad_q;

	logic [COUNT_W-1:0]         limit;
	logic [BIN_W-1:0]           rd_addr;
	logic [dsc_pkg::WORD_W-1:0] ram_rdata;
	logic signed [PROD_W-1:0]   prod_re;
	logic signed [PROD_W-1:0]   prod_im;
	logic                       out_free;

	logic                       out_valid_q;
	logic [PROD_W-1:0]          out_re_q;
	logic [PROD_W-1:0]          out_im_q;
	logic [MAP_W-1:0]           out_map_q;
	logic                       out_bad_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= dsc_pkg::STEP_RESET;
			count_q <= dsc_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				dsc_pkg::REG_STEP:  step_q  <= pwdata[dsc_pkg::STEP_W-1:0];
				dsc_pkg::REG_COUNT: count_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dsc_pkg::REG_STEP:  prdata = 32'(step_q);
			dsc_pkg::REG_COUNT: prdata = 32'(count_q);
			default:            prdata = '0;
		endcase
	end

	// request fields
	assign in_bin = s_tdata[BIN_W-1:0];
	assign in_re  = s_tdata[BIN_W +: SAMPLE_W];
	assign in_im  = s_tdata[BIN_W+SAMPLE_W +: SAMPLE_W];
	assign in_col = s_tdata[BIN_W+2*SAMPLE_W +: COL_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;

	assign limit = (count_q > COUNT_W'(dsc_pkg::MAX_COLUMNS)) ?
		COUNT_W'(dsc_pkg::MAX_COLUMNS) : count_q;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc && s_tuser == dsc_pkg::KIND_CORRELATE) begin
					state_q <= ST_OFFS;
				end
				ST_OFFS: state_q <= ST_READ;
				ST_READ: state_q <= ST_MULT;
				ST_MULT: state_q <= ST_SUM;
				ST_SUM:  if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bin_q <= in_bin;
			re_q  <= in_re;
			im_q  <= in_im;
			col_q <= in_col;
		end
		if (state_q == ST_OFFS) begin
			bad_q <= COUNT_W'(col_q) >= limit;
		end
	end

	dsc_addr_gen u_addr_gen (
		.clk       (clk),
		.en        (state_q == ST_OFFS),
		.step      (step_q),
		.column    (col_q),
		.bin_index (bin_q),
		.rd_addr   (rd_addr)
	);

	// loads write straight from the request; reads happen in ST_READ, after the offset multiply
	dsc_ram #(
		.WIDTH (dsc_pkg::WORD_W),
		.DEPTH (dsc_pkg::SPECTRUM_LENGTH)
	) u_spectrum_ram (
		.clk   (clk),
		.we    (in_acc && s_tuser == dsc_pkg::KIND_LOAD),
		.waddr (in_bin),
		.wdata ({in_re, in_im}),
		.re    (state_q == ST_READ && !bad_q),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	dsc_cmul u_cmul (
		.clk      (clk),
		.en       (state_q == ST_MULT),
		.ref_re   (re_q),
		.ref_im   (im_q),
		.bin_word (ram_rdata),
		.prod_re  (prod_re),
		.prod_im  (prod_im)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_SUM && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM && out_free) begin
			out_bad_q <= bad_q;
			if (bad_q) begin
				out_re_q  <= '0;
				out_im_q  <= '0;
				out_map_q <= '0;
			end else begin
				out_re_q  <= prod_re;
				out_im_q  <= prod_im;
				out_map_q <= MAP_W'(bin_q) + (MAP_W'(col_q) << BIN_W);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_map_q, out_im_q, out_re_q};
	assign m_tuser  = out_bad_q;

endmodule
